[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holding at an edge implies cons at the same edge
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante holding at an edge implies cons at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// expr never holds at any edge
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[rtl/sbbl_pkg.sv]
// package for the spectrum bar bounce levels block: widths, constants, band table, codes
`timescale 1ns / 1ps

package sbbl_pkg;

  // bar and item geometry
  localparam int NUM_BARS = 32;
  localparam int BAR_W    = $clog2(NUM_BARS);
  localparam int BIN_W    = 9;
  localparam int COMP_W   = 16;
  localparam int LEVEL_W  = 16;
  localparam int ENERGY_W = 36;
  localparam int VEL_W    = 18;
  localparam int KIND_W   = 2;

  // stream widths, padded to whole bytes
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 24;

  // fixed point constants; levels and acceleration in Q1.15
  localparam int LEVEL_ONE  = 32768;
  localparam int ACCEL_Q15  = 3277;
  localparam int ENERGY_ONE = 10000;
  localparam int VEL_ROUND  = 5;

  // shared multiplier sizes
  localparam int MUL_A_W = 29;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // level = floor(e * 2^15 / 10000) as e * LVL_K >> LVL_SHIFT, exact for e < 10000
  localparam logic [MUL_A_W-1:0] LVL_K = 29'd439804652;
  localparam int LVL_SHIFT = 27;
  // floor(x / 10) as x * VEL_K >> VEL_SHIFT, exact for x < 2^17
  localparam logic [MUL_A_W-1:0] VEL_K = 29'd209716;
  localparam int VEL_SHIFT = 21;
  // level times factor back to Q1.15
  localparam int OUT_SHIFT = 15;

  // bin range of each bar: lo <= bin < hi, log spaced over a 512 bin chunk
  localparam logic [BIN_W-1:0] BAND_LO [NUM_BARS] = '{
    9'd0,   9'd0,   9'd0,   9'd0,   9'd1,   9'd1,   9'd2,   9'd2,
    9'd3,   9'd4,   9'd6,   9'd7,   9'd9,   9'd11,  9'd14,  9'd17,
    9'd21,  9'd26,  9'd32,  9'd39,  9'd48,  9'd58,  9'd71,  9'd87,
    9'd106, 9'd129, 9'd157, 9'd192, 9'd233, 9'd284, 9'd345, 9'd420
  };
  localparam logic [BIN_W-1:0] BAND_HI [NUM_BARS] = '{
    9'd1,   9'd1,   9'd1,   9'd2,   9'd2,   9'd3,   9'd3,   9'd4,
    9'd5,   9'd7,   9'd8,   9'd10,  9'd12,  9'd15,  9'd18,  9'd22,
    9'd27,  9'd33,  9'd40,  9'd49,  9'd59,  9'd72,  9'd88,  9'd107,
    9'd130, 9'd158, 9'd193, 9'd234, 9'd285, 9'd346, 9'd421, 9'd511
  };

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_BIN  = 2'd0,
    KIND_BEAT = 2'd1,
    KIND_TICK = 2'd2
  } kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_ACC,
    S_LVL,
    S_VEL,
    S_BNC,
    S_MUL,
    S_OUT
  } state_t;

endpackage

[rtl/spectrum_bar_bounce_levels_top.sv]
// spectrum bar levels with bounce animation, sequenced over one shared multiplier
//
//  channel  dir  fields (tdata / tuser / tlast)
//  s_axis   in   tdata: bin_index, comp_a, comp_b   tuser: kind
//  m_axis   out  tdata: bar_index, bar_level        tlast: last_bar
//
// a bin request: sum and square, then the energy sweep over every bar
// a beat request arms capture; an unknown kind is dropped
// a frame tick steps each bar through S_BNC, S_MUL and S_OUT, with S_LVL and S_VEL first when
// capture is armed, and stalls while m_axis_tready stays low; the steps share the one
// 29x17 multiplier
// synchronous active high reset clears all bar state and the armed flag
// s_axis_tready is high only while idle; a result holds on m_axis until taken
`timescale 1ns / 1ps

module spectrum_bar_bounce_levels_top
  import sbbl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // bin_index[8:0], comp_a[24:9], comp_b[40:25]
  input  logic [KIND_W-1:0]    s_axis_tuser,   // kind[1:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // bar_index[4:0], bar_level[20:5]
  output logic                 m_axis_tlast    // last_bar
);

  state_t state, state_next;

  logic [BAR_W-1:0] bar;
  logic             bar_last;
  logic             armed;
  logic             capture;
  logic             all_zero;

  logic [BIN_W-1:0]   bin_q;
  logic [MUL_B_W-1:0] mag_q;

  logic [ENERGY_W-1:0] energy   [NUM_BARS];
  logic [LEVEL_W-1:0]  held     [NUM_BARS];
  logic [LEVEL_W-1:0]  factor   [NUM_BARS];
  logic [VEL_W-1:0]    velocity [NUM_BARS];
  logic [NUM_BARS-1:0] accel_on;

  logic in_acc;
  logic out_acc;
  kind_t kind_in;

  logic signed [COMP_W:0] comp_sum;
  logic [MUL_B_W-1:0]     comp_mag;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  logic [ENERGY_W:0]   e_sum;
  logic [ENERGY_W-1:0] e_next;
  logic                in_band;

  logic [LEVEL_W-1:0] lvl_new;
  logic [MUL_B_W-1:0] vel_num;

  logic signed [VEL_W-1:0] v_cur;
  logic                    a_cur;
  logic signed [VEL_W+1:0] f_sum;
  logic signed [VEL_W:0]   v_acc;
  logic signed [VEL_W-1:0] v_step;
  logic signed [VEL_W-1:0] v_half;
  logic signed [VEL_W:0]   v_neg;
  logic signed [VEL_W-1:0] v_next;
  logic [LEVEL_W-1:0]      f_next;
  logic                    a_next;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign kind_in  = kind_t'(s_axis_tuser);
  assign bar_last = (bar == BAR_W'(NUM_BARS - 1));

  // magnitude of the summed components
  assign comp_sum = $signed({s_axis_tdata[BIN_W+COMP_W-1], s_axis_tdata[BIN_W +: COMP_W]})
                  + $signed({s_axis_tdata[BIN_W+2*COMP_W-1],
                             s_axis_tdata[BIN_W+COMP_W +: COMP_W]});
  assign comp_mag = comp_sum[COMP_W] ? MUL_B_W'(-comp_sum) : MUL_B_W'(comp_sum);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ, S_ACC: begin
        mul_a = MUL_A_W'(mag_q);
        mul_b = mag_q;
      end
      S_LVL: begin
        mul_a = LVL_K;
        mul_b = MUL_B_W'(energy[bar][13:0]);
      end
      S_VEL: begin
        mul_a = VEL_K;
        mul_b = vel_num;
      end
      S_MUL, S_OUT: begin
        mul_a = MUL_A_W'(held[bar]);
        mul_b = MUL_B_W'(factor[bar]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // saturating energy add for the bar under the sweep
  assign in_band = (bin_q >= BAND_LO[bar]) && (bin_q < BAND_HI[bar]);
  assign e_sum   = {1'b0, energy[bar]} + (ENERGY_W + 1)'(prod[2*MUL_B_W-1:0]);
  assign e_next  = e_sum[ENERGY_W] ? {ENERGY_W{1'b1}} : e_sum[ENERGY_W-1:0];

  // captured level and rounded velocity numerator 3*level + 5
  assign lvl_new = (energy[bar] >= ENERGY_W'(ENERGY_ONE)) ? LEVEL_W'(LEVEL_ONE)
                                                          : prod[LVL_SHIFT +: LEVEL_W];
  assign vel_num = MUL_B_W'(lvl_new) + (MUL_B_W'(lvl_new) << 1) + MUL_B_W'(VEL_ROUND);

  // one bounce step for the current bar
  always_comb begin
    v_cur  = capture ? $signed(prod[VEL_SHIFT +: VEL_W]) : $signed(velocity[bar]);
    a_cur  = capture | accel_on[bar];
    f_sum  = $signed({4'b0, factor[bar]}) + $signed({{2{v_cur[VEL_W-1]}}, v_cur});
    v_acc  = $signed({v_cur[VEL_W-1], v_cur}) + $signed((VEL_W + 1)'(ACCEL_Q15));
    v_step = v_cur;
    if (a_cur) begin
      if (v_acc > $signed((VEL_W + 1)'((1 << (VEL_W - 1)) - 1))) begin
        v_step = $signed(VEL_W'((1 << (VEL_W - 1)) - 1));
      end else begin
        v_step = v_acc[VEL_W-1:0];
      end
    end
    // halve toward zero, then negate; the result always fits the velocity range
    v_half = (v_step + $signed({{(VEL_W-1){1'b0}}, v_step[VEL_W-1]})) >>> 1;
    v_neg  = -$signed({v_half[VEL_W-1], v_half});
    v_next = v_step;
    a_next = a_cur;
    if (f_sum < 0) begin
      f_next = '0;
    end else if (f_sum > $signed((VEL_W + 2)'(LEVEL_ONE))) begin
      f_next = LEVEL_W'(LEVEL_ONE);
      v_next = v_neg[VEL_W-1:0];
      a_next = 1'b0;
    end else begin
      f_next = f_sum[LEVEL_W-1:0];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          case (kind_in)
            KIND_BIN:  state_next = S_SQ;
            KIND_TICK: state_next = armed ? S_LVL : S_BNC;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_SQ:  state_next = S_ACC;
      S_ACC: if (bar_last) begin
        state_next = S_IDLE;
      end
      S_LVL: state_next = S_VEL;
      S_VEL: state_next = S_BNC;
      S_BNC: state_next = S_MUL;
      S_MUL: state_next = S_OUT;
      S_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          if (bar_last) begin
            state_next = S_IDLE;
          end else begin
            state_next = capture ? S_LVL : S_BNC;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer control: bar counter, armed, capture and all-zero flags
  always_ff @(posedge clk) begin
    if (rst) begin
      bar      <= '0;
      armed    <= 1'b0;
      capture  <= 1'b0;
      all_zero <= 1'b0;
    end else begin
      if (in_acc) begin
        bar <= '0;
        if (kind_in == KIND_BEAT) begin
          armed <= 1'b1;
        end
        if (kind_in == KIND_TICK) begin
          capture  <= armed;
          armed    <= 1'b0;
          all_zero <= 1'b1;
        end
      end
      if (state == S_ACC) begin
        bar <= bar + 1'b1;
      end
      if (state == S_BNC && f_next != '0) begin
        all_zero <= 1'b0;
      end
      if (state == S_OUT && out_acc) begin
        bar <= bar + 1'b1;
        if (bar_last) begin
          armed <= armed | all_zero;
        end
      end
    end
  end

  // request payload capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      bin_q <= s_axis_tdata[BIN_W-1:0];
      mag_q <= comp_mag;
    end
  end

  // per-bar state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BARS; i++) begin
        energy[i]   <= '0;
        held[i]     <= '0;
        factor[i]   <= '0;
        velocity[i] <= '0;
      end
      accel_on <= '0;
    end else begin
      case (state)
        S_ACC: if (in_band) begin
          energy[bar] <= e_next;
        end
        S_VEL: held[bar] <= lvl_new;
        S_BNC: begin
          factor[bar]   <= f_next;
          velocity[bar] <= v_next;
          accel_on[bar] <= a_next;
          energy[bar]   <= '0;
        end
        default: ;
      endcase
    end
  end

  // result payload straight from the product register
  assign m_axis_tdata = {{(M_TDATA_W - BAR_W - LEVEL_W){1'b0}},
                         prod[OUT_SHIFT +: LEVEL_W], bar};
  assign m_axis_tlast = bar_last;

endmodule

[rtl/sbbl_checker.sv]
// port-level checker for the spectrum bar bounce levels block, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbbl_checker
  import sbbl_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast
);

  // no new request is taken while a result is on offer
  `ASSERT_NEVER(a_busy_while_out, clk, rst, s_axis_tready && m_axis_tvalid, "ready during result")

  // a frame keeps going after every bar but the last
  `ASSERT_NEXT(a_frame_runs, clk, rst, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !s_axis_tready, "frame ended early")

  // tlast marks exactly the final bar
  `ASSERT_IMPLIES(a_last_bar, clk, rst, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[BAR_W-1:0] == BAR_W'(NUM_BARS - 1)), "tlast off final bar")

  // bar level never exceeds full scale
  `ASSERT_IMPLIES(a_level_max, clk, rst, m_axis_tvalid, m_axis_tdata[BAR_W +: LEVEL_W] <= LEVEL_W'(LEVEL_ONE), "level above full scale")

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

endmodule

bind spectrum_bar_bounce_levels_top sbbl_checker u_sbbl_checker (.*);
